// ===== sv/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Types and codes shared by the seven-segment LED renderer modules.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Input item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Draw modes
  localparam logic [1:0] DRAW_ALL   = 2'd0;
  localparam logic [1:0] DRAW_LIT   = 2'd1;
  localparam logic [1:0] DRAW_UNLIT = 2'd2;

  // Segment numbers, A is bit 0 of the pattern
  localparam logic [2:0] SEG_A    = 3'd0;
  localparam logic [2:0] SEG_B    = 3'd1;
  localparam logic [2:0] SEG_C    = 3'd2;
  localparam logic [2:0] SEG_D    = 3'd3;
  localparam logic [2:0] SEG_E    = 3'd4;
  localparam logic [2:0] SEG_F    = 3'd5;
  localparam logic [2:0] SEG_G    = 3'd6;
  localparam logic [2:0] SEG_NONE = 3'd7;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_PATTERN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAINT_BACKGROUND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET    = 3'd5;

  typedef struct packed {
    logic        op;
    logic [7:0]  row;
    logic [7:0]  column;
    logic        lit_store;
    logic [23:0] write_color;
  } in_item_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_color;
  } out_item_t;

  // Decoded item leaving the locate stage
  typedef struct packed {
    logic        op;
    logic [2:0]  seg;
    logic        lit_store;
    logic [23:0] write_color;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } dec_t;

  // Draw decision leaving the store-access stage
  typedef struct packed {
    logic        draw;
    logic        use_bg;
    logic        use_lit;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } pick_t;

endpackage

// ===== sv/ssr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ssr_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_decode
// Input register and segment locate stage: grid position to segment, store
// index and offset pixel coordinates.
// ----------------------------------------------------------------------------
module ssr_decode #(
  parameter int LEDS_PER_SEGMENT = 4
) (
  input  logic                                 clk,
  input  logic                                 advance,
  input  ssr_pkg::in_item_t                    in_item,
  input  logic [15:0]                          row_offset,
  input  logic [15:0]                          column_offset,
  output ssr_pkg::dec_t                        dec,
  output logic [$clog2(7*LEDS_PER_SEGMENT)-1:0] idx
);
  import ssr_pkg::*;

  localparam int IW = $clog2(7*LEDS_PER_SEGMENT);
  localparam int PW = (LEDS_PER_SEGMENT > 1) ? $clog2(LEDS_PER_SEGMENT) : 1;
  localparam logic [7:0] LEN     = 8'(LEDS_PER_SEGMENT);
  localparam logic [7:0] MIDDLE  = 8'(LEDS_PER_SEGMENT + 1);
  localparam logic [7:0] LOWER   = 8'(LEDS_PER_SEGMENT + 2);
  localparam logic [7:0] BOTTOM  = 8'(2*LEDS_PER_SEGMENT + 2);

  in_item_t       s1;
  logic [2:0]     seg;
  logic [7:0]     pos_full;
  logic [PW-1:0]  pos;
  logic [IW-1:0]  idx_next;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= in_item;
    end
  end

  always_comb begin
    seg = SEG_NONE;
    if (s1.row <= BOTTOM) begin
      if (s1.row == 8'd0 || s1.row == MIDDLE || s1.row == BOTTOM) begin
        if (s1.column >= 8'd1 && s1.column <= LEN) begin
          if (s1.row == 8'd0) begin
            seg = SEG_A;
          end else if (s1.row == MIDDLE) begin
            seg = SEG_G;
          end else begin
            seg = SEG_D;
          end
        end
      end else if (s1.column == 8'd0) begin
        seg = (s1.row < MIDDLE) ? SEG_F : SEG_E;
      end else if (s1.column == MIDDLE) begin
        seg = (s1.row < MIDDLE) ? SEG_B : SEG_C;
      end
    end
  end

  always_comb begin
    case (seg)
      SEG_A, SEG_D, SEG_G: pos_full = s1.column - 8'd1;
      SEG_B, SEG_F:        pos_full = s1.row - 8'd1;
      default:             pos_full = s1.row - LOWER;
    endcase
    pos      = pos_full[PW-1:0];
    idx_next = IW'(seg) * IW'(LEDS_PER_SEGMENT) + IW'(pos);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dec.op          <= s1.op;
      dec.seg         <= seg;
      dec.lit_store   <= s1.lit_store;
      dec.write_color <= s1.write_color;
      dec.pixel_x     <= {8'd0, s1.column} + column_offset;
      dec.pixel_y     <= {8'd0, s1.row} + row_offset;
      idx             <= idx_next;
    end
  end

endmodule

// ===== sv/ssr_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_color
// Colour store stage and colour select: writes the lit or unlit store, reads
// both for renders, applies pattern and draw mode, forms the result.
// ----------------------------------------------------------------------------
module ssr_color #(
  parameter int LEDS_PER_SEGMENT = 4
) (
  input  logic                                  clk,
  input  logic                                  advance,
  input  logic                                  dec_valid,
  input  ssr_pkg::dec_t                         dec,
  input  logic [$clog2(7*LEDS_PER_SEGMENT)-1:0] idx,
  input  logic [6:0]                            segment_pattern,
  input  logic [1:0]                            draw_mode,
  input  logic                                  paint_background,
  input  logic [23:0]                           background_color,
  output ssr_pkg::out_item_t                    result
);
  import ssr_pkg::*;

  localparam int DEPTH = 7*LEDS_PER_SEGMENT;

  logic        on_seg;
  logic        seg_on;
  logic        allowed;
  logic        wr;
  pick_t       pick_next;
  pick_t       pick;
  logic [23:0] lit_q;
  logic [23:0] unlit_q;
  logic [23:0] color;

  always_comb begin
    on_seg  = (dec.seg != SEG_NONE);
    seg_on  = segment_pattern[dec.seg];
    allowed = (draw_mode == DRAW_ALL) || (draw_mode == DRAW_LIT && seg_on) ||
              (draw_mode == DRAW_UNLIT && !seg_on);
    // store update happens once, on the cycle the transaction moves on
    wr      = advance && dec_valid && (dec.op == OP_WRITE) && on_seg;

    pick_next.use_bg  = !on_seg;
    pick_next.use_lit = seg_on;
    pick_next.draw    = (dec.op == OP_RENDER) &&
                        (on_seg ? allowed : paint_background);
    pick_next.pixel_x = dec.pixel_x;
    pick_next.pixel_y = dec.pixel_y;
  end

  ssr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_lit_ram (
    .clk   (clk),
    .we    (wr && dec.lit_store),
    .waddr (idx),
    .wdata (dec.write_color),
    .re    (advance),
    .raddr (idx),
    .rdata (lit_q)
  );

  ssr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_unlit_ram (
    .clk   (clk),
    .we    (wr && !dec.lit_store),
    .waddr (idx),
    .wdata (dec.write_color),
    .re    (advance),
    .raddr (idx),
    .rdata (unlit_q)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      pick <= pick_next;
    end
  end

  always_comb begin
    if (pick.use_bg) begin
      color = background_color;
    end else begin
      color = pick.use_lit ? lit_q : unlit_q;
    end
    if (pick.draw) begin
      result.emit        = 1'b1;
      result.pixel_x     = pick.pixel_x;
      result.pixel_y     = pick.pixel_y;
      result.pixel_color = color;
    end else begin
      result = '0;
    end
  end

endmodule

// ===== sv/seven_segment_led_renderer.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per clock; the four register stages (input,
// locate, colour store read, output) advance together and all hold on stall.
// Reset clears the stage valid flags and the configuration registers; the
// colour stores are not cleared and must be written before being rendered.
// ----------------------------------------------------------------------------
// seven_segment_led_renderer
// Renders one seven-segment digit of LED strips onto a matrix, with lit and
// unlit colour stores per segment LED.
// ----------------------------------------------------------------------------
module seven_segment_led_renderer #(
  parameter int LEDS_PER_SEGMENT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ssr_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ssr_pkg::out_item_t                  out_item,
  input  logic                                cfg_write,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ssr_pkg::*;

  localparam int IW = $clog2(7*LEDS_PER_SEGMENT);

  logic [6:0]  segment_pattern;
  logic [1:0]  draw_mode;
  logic        paint_background;
  logic [23:0] background_color;
  logic [15:0] row_offset;
  logic [15:0] column_offset;

  logic          advance;
  logic          v1;
  logic          v2;
  logic          v3;
  dec_t          dec;
  logic [IW-1:0] idx;
  out_item_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_pattern  <= '0;
      draw_mode        <= '0;
      paint_background <= 1'b0;
      background_color <= '0;
      row_offset       <= '0;
      column_offset    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEGMENT_PATTERN:  segment_pattern  <= cfg_data[6:0];
        CFG_DRAW_MODE:        draw_mode        <= cfg_data[1:0];
        CFG_PAINT_BACKGROUND: paint_background <= cfg_data[0];
        CFG_BACKGROUND_COLOR: background_color <= cfg_data[23:0];
        CFG_ROW_OFFSET:       row_offset       <= cfg_data[15:0];
        CFG_COLUMN_OFFSET:    column_offset    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless a finished result is held by the sink
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  ssr_decode #(.LEDS_PER_SEGMENT(LEDS_PER_SEGMENT)) u_decode (
    .clk           (clk),
    .advance       (advance),
    .in_item       (in_item),
    .row_offset    (row_offset),
    .column_offset (column_offset),
    .dec           (dec),
    .idx           (idx)
  );

  ssr_color #(.LEDS_PER_SEGMENT(LEDS_PER_SEGMENT)) u_color (
    .clk              (clk),
    .advance          (advance),
    .dec_valid        (v2),
    .dec              (dec),
    .idx              (idx),
    .segment_pattern  (segment_pattern),
    .draw_mode        (draw_mode),
    .paint_background (paint_background),
    .background_color (background_color),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ===== sv/ssr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks for the seven-segment LED renderer, bound to the top.
// ----------------------------------------------------------------------------
module ssr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ssr_pkg::out_item_t out_item
);
  import ssr_pkg::*;

  // input is only held back by a result waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a result that draws nothing carries all-zero fields
  a_no_draw_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.emit) |->
      (out_item.pixel_x == 16'd0 && out_item.pixel_y == 16'd0 &&
       out_item.pixel_color == 24'd0))
    else $error("non-drawn result with non-zero fields");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind seven_segment_led_renderer ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/tb_seven_segment_led_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_led_renderer
// Self-checking bench for the seven-segment LED renderer. A short table of
// directed transactions is followed by random phases. Each phase writes every
// register and then mixes colour writes with render requests. An in-bench
// digit model predicts each result the table leaves open. Both handshakes are
// throttled at random, and one long output hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_seven_segment_led_renderer;
  import ssr_pkg::*;

  localparam int LEDS = 4;
  localparam int SLOTS = 7 * LEDS;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 106;
  localparam logic [1:0] DRAW_NONE = 2'd3;  // unused mode code

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  seven_segment_led_renderer #(
    .LEDS_PER_SEGMENT(LEDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the digit: register copies and both colour stores
  logic [6:0] seg_pattern;
  logic [1:0] draw_sel;
  logic paint_bg;
  logic [23:0] bg_rgb;
  logic [15:0] y_off;
  logic [15:0] x_off;
  logic [23:0] lit_rgb[SLOTS];
  logic [23:0] unlit_rgb[SLOTS];
  logic lit_set[SLOTS];
  logic unlit_set[SLOTS];

  out_item_t pixel_queue[$];

  int failures;
  int n_sent;
  int n_writes;
  int n_drawn;
  int n_settings;
  logic steady;
  logic hold_req;

  typedef struct {
    logic is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t item;
    logic typed;
    out_item_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic logic [2:0] segment_at(logic [7:0] r, logic [7:0] c);
    int mid;
    int bottom;
    mid = LEDS + 1;
    bottom = 2 * mid;
    if (r > bottom) return SEG_NONE;
    if (r == 0 || r == mid || r == bottom) begin
      if (c >= 1 && c <= LEDS) return (r == 0) ? SEG_A : ((r == mid) ? SEG_G : SEG_D);
      return SEG_NONE;
    end
    if (c == 0) return (r < mid) ? SEG_F : SEG_E;
    if (c == LEDS + 1) return (r < mid) ? SEG_B : SEG_C;
    return SEG_NONE;
  endfunction

  function automatic int led_slot(logic [2:0] seg, logic [7:0] r, logic [7:0] c);
    int pos;
    case (seg)
      SEG_A, SEG_D, SEG_G: pos = int'(c) - 1;
      SEG_B, SEG_F: pos = int'(r) - 1;
      default: pos = int'(r) - LEDS - 2;
    endcase
    return int'(seg) * LEDS + pos;
  endfunction

  function automatic logic draws_segment(logic [2:0] seg);
    logic on;
    on = seg_pattern[seg];
    return (draw_sel == DRAW_ALL) || (draw_sel == DRAW_LIT && on) ||
           (draw_sel == DRAW_UNLIT && !on);
  endfunction

  // Applies one transaction to the shadow and returns the pixel it yields
  function automatic out_item_t render_pixel(in_item_t it);
    out_item_t px;
    logic [2:0] seg;
    int slot;
    px = '0;
    seg = segment_at(it.row, it.column);
    if (it.op == OP_WRITE) begin
      if (seg != SEG_NONE) begin
        slot = led_slot(seg, it.row, it.column);
        if (it.lit_store) begin
          lit_rgb[slot] = it.write_color;
          lit_set[slot] = 1'b1;
        end else begin
          unlit_rgb[slot] = it.write_color;
          unlit_set[slot] = 1'b1;
        end
      end
      return px;
    end
    if (seg != SEG_NONE) begin
      if (draws_segment(seg)) begin
        slot = led_slot(seg, it.row, it.column);
        px.emit = 1'b1;
        px.pixel_color = seg_pattern[seg] ? lit_rgb[slot] : unlit_rgb[slot];
      end
    end else if (paint_bg) begin
      px.emit = 1'b1;
      px.pixel_color = bg_rgb;
    end
    if (px.emit) begin
      px.pixel_x = 16'(it.column) + x_off;
      px.pixel_y = 16'(it.row) + y_off;
    end
    return px;
  endfunction

  function automatic plan_row_t step_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic plan_row_t step_in(logic op, logic [7:0] r, logic [7:0] c, logic lit,
                                        logic [23:0] rgb, logic typed, out_item_t want);
    plan_row_t s;
    s = '{default: '0};
    s.item.op = op;
    s.item.row = r;
    s.item.column = c;
    s.item.lit_store = lit;
    s.item.write_color = rgb;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SEGMENT_PATTERN: seg_pattern = data[6:0];
      CFG_DRAW_MODE: draw_sel = data[1:0];
      CFG_PAINT_BACKGROUND: paint_bg = data[0];
      CFG_BACKGROUND_COLOR: bg_rgb = data[23:0];
      CFG_ROW_OFFSET: y_off = data[15:0];
      CFG_COLUMN_OFFSET: x_off = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stops offering and waits for every outstanding pixel
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    int r;
    out_item_t px;
    r = $urandom_range(0, 99);
    gap = steady ? 0 : (r < 60 ? 0 : (r < 94 ? $urandom_range(1, 3) : $urandom_range(8, 25)));
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    px = render_pixel(it);
    pixel_queue.push_back(typed ? want : px);
    n_sent++;
    if (it.op == OP_WRITE) n_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("seven_segment_led_renderer verification failed");
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int r;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(8, 30);
        end
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected transaction on output: %p", out_item);
        failures++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_item.emit === 1'b1) n_drawn++;
        if (out_item.emit !== want.emit) begin
          $error("emit mismatch: expected %h, actual %h", want.emit, out_item.emit);
          failures++;
        end
        if (out_item.pixel_x !== want.pixel_x) begin
          $error("pixel_x mismatch: expected %h, actual %h", want.pixel_x, out_item.pixel_x);
          failures++;
        end
        if (out_item.pixel_y !== want.pixel_y) begin
          $error("pixel_y mismatch: expected %h, actual %h", want.pixel_y, out_item.pixel_y);
          failures++;
        end
        if (out_item.pixel_color !== want.pixel_color) begin
          $error("pixel_color mismatch: expected %h, actual %h",
                 want.pixel_color, out_item.pixel_color);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    logic [2:0] seg;
    logic on;
    int slot;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_SEGMENT_PATTERN;
    cfg_data = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    failures = 0;
    n_sent = 0;
    n_writes = 0;
    n_drawn = 0;
    n_settings = 0;
    seg_pattern = '0;
    draw_sel = DRAW_ALL;
    paint_bg = 1'b0;
    bg_rgb = '0;
    y_off = '0;
    x_off = '0;
    for (int i = 0; i < SLOTS; i++) begin
      lit_rgb[i] = '0;
      unlit_rgb[i] = '0;
      lit_set[i] = 1'b0;
      unlit_set[i] = 1'b0;
    end

    // Directed: grid corners, wrap of the offsets, every draw mode
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd0, 1'b0, 24'h0, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd0, 8'd0, 1'b1, 24'hFFFFFF, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd255, 8'd255, 1'b1, 24'hFFFFFF, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd0, 8'd1, 1'b1, 24'hFFFFFF, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd0, 8'd1, 1'b0, 24'h000000, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd0, 8'd4, 1'b1, 24'h123456, 1'b1, '0));
    plan.push_back(step_in(OP_WRITE, 8'd0, 8'd4, 1'b0, 24'hABCDEF, 1'b1, '0));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd1, 1'b1, 24'hFFFFFF, 1'b0, '0));
    plan.push_back(step_in(OP_RENDER, 8'd255, 8'd255, 1'b1, 24'hFFFFFF, 1'b1, '0));
    plan.push_back(step_cfg(CFG_SEGMENT_PATTERN, 24'h7F));
    plan.push_back(step_cfg(CFG_PAINT_BACKGROUND, 24'h1));
    plan.push_back(step_cfg(CFG_BACKGROUND_COLOR, 24'hFFFFFF));
    plan.push_back(step_cfg(CFG_ROW_OFFSET, 24'hFFFF));
    plan.push_back(step_cfg(CFG_COLUMN_OFFSET, 24'hFFFF));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd1, 1'b0, 24'h0, 1'b0, '0));
    plan.push_back(step_in(OP_RENDER, 8'd255, 8'd255, 1'b0, 24'h0, 1'b0, '0));
    plan.push_back(step_in(OP_RENDER, 8'd1, 8'd1, 1'b0, 24'h0, 1'b0, '0));
    plan.push_back(step_cfg(CFG_DRAW_MODE, 24'(DRAW_NONE)));
    plan.push_back(step_cfg(CFG_SEGMENT_PATTERN, 24'h0));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd4, 1'b0, 24'h0, 1'b1, '0));
    plan.push_back(step_in(OP_RENDER, 8'd5, 8'd5, 1'b0, 24'h0, 1'b0, '0));
    plan.push_back(step_cfg(CFG_DRAW_MODE, 24'(DRAW_LIT)));
    plan.push_back(step_cfg(CFG_SEGMENT_PATTERN, 24'h01));
    plan.push_back(step_cfg(CFG_PAINT_BACKGROUND, 24'h0));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd4, 1'b0, 24'h0, 1'b0, '0));
    plan.push_back(step_in(OP_RENDER, 8'd5, 8'd5, 1'b0, 24'h0, 1'b1, '0));
    plan.push_back(step_cfg(CFG_SEGMENT_PATTERN, 24'h0));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd4, 1'b0, 24'h0, 1'b1, '0));
    plan.push_back(step_cfg(CFG_DRAW_MODE, 24'(DRAW_UNLIT)));
    plan.push_back(step_in(OP_RENDER, 8'd0, 8'd4, 1'b0, 24'h0, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      steady = (phase % 5 == 2);
      set_reg(CFG_SEGMENT_PATTERN,
              phase == 0 ? 24'h0 : (phase == 1 ? 24'h7F : 24'($urandom_range(0, 127))));
      set_reg(CFG_DRAW_MODE,
              phase % 5 == 4 ? 24'($urandom_range(0, 3)) : 24'(phase % 4));
      set_reg(CFG_PAINT_BACKGROUND, phase < 2 ? 24'(phase) : 24'($urandom_range(0, 1)));
      set_reg(CFG_BACKGROUND_COLOR,
              phase == 0 ? 24'h0 : (phase == 1 ? 24'hFFFFFF : 24'($urandom_range(0, 24'hFFFFFF))));
      set_reg(CFG_ROW_OFFSET,
              phase == 0 ? 24'h0 : (phase == 1 ? 24'hFFFF :
              ($urandom_range(0, 3) == 0 ? 24'($urandom_range(16'hFFF0, 16'hFFFF)) :
               24'($urandom_range(0, 16'hFFFF)))));
      set_reg(CFG_COLUMN_OFFSET,
              phase == 0 ? 24'h0 : (phase == 1 ? 24'hFFFF :
              ($urandom_range(0, 3) == 0 ? 24'($urandom_range(16'hFFF0, 16'hFFFF)) :
               24'($urandom_range(0, 16'hFFFF)))));
      n_settings++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 20) hold_req = 1'b1;
        it.op = ($urandom_range(0, 99) < 40) ? OP_WRITE : OP_RENDER;
        if ($urandom_range(0, 99) < 85) begin
          it.row = 8'($urandom_range(0, 2 * LEDS + 2));
          it.column = 8'($urandom_range(0, LEDS + 1));
        end else begin
          it.row = 8'($urandom_range(0, 255));
          it.column = 8'($urandom_range(0, 255));
        end
        it.lit_store = 1'($urandom_range(0, 1));
        it.write_color = 24'($urandom_range(0, 24'hFFFFFF));
        // a render that would read a colour never stored becomes the store write
        seg = segment_at(it.row, it.column);
        if (it.op == OP_RENDER && seg != SEG_NONE && draws_segment(seg)) begin
          slot = led_slot(seg, it.row, it.column);
          on = seg_pattern[seg];
          if (!(on ? lit_set[slot] : unlit_set[slot])) begin
            it.op = OP_WRITE;
            it.lit_store = on;
          end
        end
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d transactions: %0d colour writes, %0d renders, %0d pixels drawn,",
             n_sent, n_writes, n_sent - n_writes, n_drawn);
    $display("across directed checks and %0d random register settings.", n_settings);
    if (failures == 0) begin
      $display("seven_segment_led_renderer verification clean");
    end else begin
      $display("seven_segment_led_renderer verification failed");
    end
    $finish;
  end

endmodule

// ===== seven_segment_led_renderer.f =====
sv/ssr_pkg.sv
sv/ssr_ram.sv
sv/ssr_decode.sv
sv/ssr_color.sv
sv/seven_segment_led_renderer.sv
sv/ssr_checker.sv
tb/tb_seven_segment_led_renderer.sv
